// ----- rtl/pba_pkg.sv -----
`timescale 1ns / 1ps
package pba_pkg;

   localparam int STORE_WORDS_DEF = 1024;
   localparam int WORD_W          = 32;
   localparam int IDX_W           = 15;
   localparam int WIDTH_W         = 6;
   localparam int COUNT_W         = 16;
   localparam int BITPOS_W        = 20;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_WIDE  = 2'd2
   } status_type;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic {
      CSR_WIDTH = 1'b0,
      CSR_COUNT = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_FETCH,
      S_MERGE,
      S_WRHI,
      S_WRLO
   } state_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] width;
      logic [COUNT_W-1:0] count;
   } cfg_type;

   function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
      logic [WIDTH_W-1:0] r;
      if (w == '0) begin
         r = WIDTH_W'(1);
      end else if (w > WIDTH_W'(WORD_W)) begin
         r = WIDTH_W'(WORD_W);
      end else begin
         r = w;
      end
      return r;
   endfunction

endpackage

// ----- rtl/pba_store.sv -----
`timescale 1ns / 1ps
module pba_store #(
   parameter int STORE_WORDS = pba_pkg::STORE_WORDS_DEF,
   parameter int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       we,
   input  logic [ADDR_W-1:0]          addr,
   input  logic [pba_pkg::WORD_W-1:0] wdata,
   output logic [pba_pkg::WORD_W-1:0] rdata,
   output logic                       ready
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_WORDS - 1);

   logic [pba_pkg::WORD_W-1:0] mem [STORE_WORDS];
   logic [pba_pkg::WORD_W-1:0] rdata_ff;
   logic                       clear_ff;
   logic                       clear_in;
   logic [ADDR_W-1:0]          clr_addr_ff;
   logic [ADDR_W-1:0]          clr_addr_in;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_addr;
   logic [pba_pkg::WORD_W-1:0] mem_wdata;

   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clear_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_comb begin
      if (clear_ff) begin
         mem_we    = 1'b1;
         mem_addr  = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = we;
         mem_addr  = addr;
         mem_wdata = wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_addr];
   end

   assign rdata = rdata_ff;
   assign ready = ~clear_ff;

endmodule

// ----- rtl/pba_ctrl.sv -----
`timescale 1ns / 1ps
module pba_ctrl #(
   parameter int STORE_WORDS = pba_pkg::STORE_WORDS_DEF,
   parameter int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pba_pkg::cfg_type            cfg,
   input  logic                        store_ready,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_operation,
   input  logic [pba_pkg::IDX_W-1:0]   req_index,
   input  logic [pba_pkg::WORD_W-1:0]  req_value,
   output logic                        rsp_valid,
   output logic [pba_pkg::WORD_W-1:0]  rsp_read_value,
   output logic [1:0]                  rsp_status,
   output logic                        mem_we,
   output logic [ADDR_W-1:0]           mem_addr,
   output logic [pba_pkg::WORD_W-1:0]  mem_wdata,
   input  logic [pba_pkg::WORD_W-1:0]  mem_rdata
);

   localparam int       WORD_W     = pba_pkg::WORD_W;
   localparam int       WIDTH_W    = pba_pkg::WIDTH_W;
   localparam int       BITPOS_W   = pba_pkg::BITPOS_W;
   localparam int       WIDX_W     = BITPOS_W - 5;
   localparam logic [63:0] STORE_BITS = 64'(STORE_WORDS) * 64'd32;
   localparam logic [63:0] STORE_LEN  = 64'(STORE_WORDS);

   pba_pkg::state_type          state_ff, state_in;
   logic                        op_ff, op_in;
   logic [pba_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [WORD_W-1:0]           val_ff, val_in;
   logic [WIDTH_W-1:0]          w_ff, w_in;
   logic [BITPOS_W-1:0]         bitpos_ff, bitpos_in;
   logic [WORD_W-1:0]           hi_ff, hi_in;
   logic [2*WORD_W-1:0]         pair_ff, pair_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]           rsp_value_ff, rsp_value_in;
   pba_pkg::status_type         rsp_status_ff, rsp_status_in;

   logic                        accept;
   logic [WIDTH_W-1:0]          req_w;
   logic [WIDX_W-1:0]           word;
   logic [4:0]                  off;
   logic [5:0]                  sh;
   logic [BITPOS_W:0]           end_bit;
   logic                        has_next;
   logic                        bad_range;
   logic [ADDR_W-1:0]           addr_hi;
   logic [ADDR_W-1:0]           addr_lo;
   logic [2*WORD_W-1:0]         mask;
   logic [2*WORD_W-1:0]         pair;
   logic [WORD_W-1:0]           lo_word;

   assign busy   = (state_ff != pba_pkg::S_IDLE) | ~store_ready;
   assign accept = start & ~busy;
   assign req_w  = pba_pkg::eff_width(cfg.width);

   assign word     = bitpos_ff[BITPOS_W-1:5];
   assign off      = bitpos_ff[4:0];
   assign sh       = 6'(7'd64 - 7'(off) - 7'(w_ff));
   assign end_bit  = (BITPOS_W+1)'(bitpos_ff) + (BITPOS_W+1)'(w_ff);
   assign has_next = (64'(word) + 64'd1) < STORE_LEN;
   assign bad_range = ({1'b0, idx_ff} >= cfg.count) || (64'(end_bit) > STORE_BITS);
   assign addr_hi  = ADDR_W'(word);
   assign addr_lo  = ADDR_W'((WIDX_W+1)'(word) + (WIDX_W+1)'(1));
   assign mask     = (64'd1 << w_ff) - 64'd1;
   assign lo_word  = has_next ? mem_rdata : '0;
   assign pair     = {hi_ff, lo_word};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      w_in          = w_ff;
      bitpos_in     = bitpos_ff;
      hi_in         = hi_ff;
      pair_in       = pair_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = pba_pkg::ST_OK;
      mem_we        = 1'b0;
      mem_addr      = addr_hi;
      mem_wdata     = pair_ff[2*WORD_W-1:WORD_W];
      case (state_ff)
         pba_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = req_operation;
               idx_in    = req_index;
               val_in    = req_value;
               w_in      = req_w;
               bitpos_in = BITPOS_W'(21'(req_index) * 21'(req_w));
               state_in  = pba_pkg::S_CHECK;
            end
         end
         pba_pkg::S_CHECK: begin
            if (bad_range) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pba_pkg::ST_RANGE;
               state_in      = pba_pkg::S_IDLE;
            end else begin
               state_in = pba_pkg::S_FETCH;
            end
         end
         pba_pkg::S_FETCH: begin
            mem_addr = addr_lo;
            hi_in    = mem_rdata;
            state_in = pba_pkg::S_MERGE;
         end
         pba_pkg::S_MERGE: begin
            if (op_ff == pba_pkg::OP_READ) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = WORD_W'((pair >> sh) & mask);
               state_in     = pba_pkg::S_IDLE;
            end else if ({32'b0, val_ff} > mask) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pba_pkg::ST_WIDE;
               state_in      = pba_pkg::S_IDLE;
            end else begin
               pair_in  = (pair & ~(mask << sh)) | ({32'b0, val_ff} << sh);
               state_in = pba_pkg::S_WRHI;
            end
         end
         pba_pkg::S_WRHI: begin
            mem_we = 1'b1;
            if (has_next) begin
               state_in = pba_pkg::S_WRLO;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = pba_pkg::S_IDLE;
            end
         end
         pba_pkg::S_WRLO: begin
            mem_we       = 1'b1;
            mem_addr     = addr_lo;
            mem_wdata    = pair_ff[WORD_W-1:0];
            rsp_valid_in = 1'b1;
            state_in     = pba_pkg::S_IDLE;
         end
         default: begin
            state_in = pba_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pba_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      w_ff          <= w_in;
      bitpos_ff     <= bitpos_in;
      hi_ff         <= hi_in;
      pair_ff       <= pair_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != pba_pkg::ST_OK) |-> rsp_value_ff == '0)
      else $error("error beat carries nonzero read value");

   a_we_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == pba_pkg::S_WRHI || state_ff == pba_pkg::S_WRLO))
      else $error("store write outside write states");

   a_wrlo_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pba_pkg::S_WRLO) |-> $past(state_ff == pba_pkg::S_WRHI))
      else $error("low word write without high word write");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == pba_pkg::S_IDLE && $past(state_ff != pba_pkg::S_IDLE)))
      else $error("response beat without finished item");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == pba_pkg::S_CHECK)
      else $error("accepted item not checked");

endmodule

// ----- rtl/packed_bitfield_array.sv -----
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// request   start, busy               req_operation, req_index, req_value
// response  rsp_valid (strobe)        rsp_read_value, rsp_status
// csr       csr_valid, csr_ready      csr_index, csr_data
//
// A read or too-wide write runs CHECK, FETCH and MERGE, a write also WRHI and, if a next word
// exists, WRLO, an index error only CHECK: one single-port store with registered read, two
// reads and up to two writes. rsp_valid is high for one cycle; the next item may start in
// that same cycle. After reset the store clears one word a cycle with busy high.
// csr writes are taken in every cycle.
module packed_bitfield_array #(
   parameter int STORE_WORDS = pba_pkg::STORE_WORDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_operation,
   input  logic [pba_pkg::IDX_W-1:0]   req_index,
   input  logic [pba_pkg::WORD_W-1:0]  req_value,
   output logic                        rsp_valid,
   output logic [pba_pkg::WORD_W-1:0]  rsp_read_value,
   output logic [1:0]                  rsp_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [pba_pkg::COUNT_W-1:0] csr_data
);

   localparam int ADDR_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

   pba_pkg::cfg_type           cfg_ff, cfg_in;
   logic                       store_ready;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_addr;
   logic [pba_pkg::WORD_W-1:0] mem_wdata;
   logic [pba_pkg::WORD_W-1:0] mem_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pba_pkg::CSR_WIDTH: cfg_in.width = csr_data[pba_pkg::WIDTH_W-1:0];
            pba_pkg::CSR_COUNT: cfg_in.count = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width <= pba_pkg::WIDTH_W'(8);
         cfg_ff.count <= pba_pkg::COUNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pba_ctrl #(
      .STORE_WORDS(STORE_WORDS),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .store_ready   (store_ready),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_index     (req_index),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_read_value(rsp_read_value),
      .rsp_status    (rsp_status),
      .mem_we        (mem_we),
      .mem_addr      (mem_addr),
      .mem_wdata     (mem_wdata),
      .mem_rdata     (mem_rdata)
   );

   pba_store #(
      .STORE_WORDS(STORE_WORDS),
      .ADDR_W     (ADDR_W)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .we   (mem_we),
      .addr (mem_addr),
      .wdata(mem_wdata),
      .rdata(mem_rdata),
      .ready(store_ready)
   );

endmodule
